@@ src/vmpf_pkg.sv @@
// Shared types and constants for the voxel map point add filter.
// No dependencies; every other file in src imports this package.
package vmpf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned VOXEL_SIZE_W = 21;
  localparam int unsigned RECIP_W      = 32;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_INDEX_W  = 2;

  // Neighbors tested against the voxel center, and the count ceiling.
  localparam logic [2:0] MATCH_POINTS = 3'd5;
  localparam logic [2:0] COUNT_MAX    = 3'd7;

  // 1e-6 m^2 in Q32.32
  localparam logic [63:0] EPS_Q32 = 64'd4295;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_VOXEL_SIZE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOXEL_RECIP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EST_READY   = 2'd2;

  // Operation field codes
  localparam logic OP_QUERY     = 1'b0;
  localparam logic OP_NEIGHBOUR = 1'b1;

  typedef enum logic {
    KIND_QUERY     = 1'b0,
    KIND_NEIGHBOUR = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    DEC_ADD_DS  = 2'd0,
    DEC_ADD_RAW = 2'd1,
    DEC_DROP    = 2'd2
  } decision_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RECIP,
    BK_SCALE,
    BK_CENTRE,
    BK_DIFF,
    BK_SQUARE,
    BK_ACCUM,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               last_of_query;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         decision;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_item_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic [VOXEL_SIZE_W-1:0] voxel_size;
    logic [RECIP_W-1:0]      voxel_reciprocal;
    logic                    estimator_ready;
  } cfg_t;

endpackage

@@ src/vmpf_front.sv @@
// Front end: accepts input transactions, drops orphan neighbors, queues the rest.
// Depends on vmpf_pkg.
module vmpf_front import vmpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_ready,
  output entry_t   q_entry
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  entry_t           slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             open_r;
  logic             open_nxt;
  logic             accept;
  logic             keep;
  logic             push;
  logic             pop;
  entry_t           new_entry;

  assign in_ready = (cnt_r != CNT_FULL);
  assign accept   = in_valid && in_ready;

  // A neighbor outside an open query has no effect downstream.
  assign keep = (in_item.operation == OP_QUERY) || open_r;
  assign push = accept && keep;
  assign pop  = q_valid && q_ready;

  assign new_entry.kind = (in_item.operation == OP_QUERY) ? KIND_QUERY : KIND_NEIGHBOUR;
  assign new_entry.x    = in_item.coord_x;
  assign new_entry.y    = in_item.coord_y;
  assign new_entry.z    = in_item.coord_z;
  assign new_entry.last = in_item.last_of_query;

  always_comb begin
    open_nxt = open_r;
    if (accept) begin
      if (in_item.operation == OP_QUERY) begin
        open_nxt = !in_item.last_of_query;
      end else if (in_item.last_of_query) begin
        open_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_entry = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      open_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      open_r <= open_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

@@ src/vmpf_back.sv @@
// Back end: sequencer over one shared 33x33 multiplier computing voxel center,
// squared distances and the decision; holds the result register. Depends on vmpf_pkg.
module vmpf_back import vmpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  entry_t    q_entry,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic signed [65:0] I32_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] I32_MIN = {{34{1'b1}}, 32'h8000_0000};

  function automatic logic signed [31:0] axis_coord(entry_t e, logic [1:0] a);
    logic signed [31:0] v;
    case (a)
      2'd0:    v = e.x;
      2'd1:    v = e.y;
      default: v = e.z;
    endcase
    return v;
  endfunction

  back_state_t state_r;
  back_state_t state_nxt;
  logic [1:0]  axis_r;
  entry_t      item_r;

  logic signed [65:0] prod_r;
  logic [31:0]        absd_r;
  logic [63:0]        acc_r;
  logic               far_run_r;

  logic signed [31:0] centre_r [3];
  logic signed [31:0] qpoint_r [3];
  logic [63:0]        thr_r;     // query distance + epsilon, saturated
  logic [2:0]         count_r;
  logic               far_r;
  logic               closer_r;

  logic               out_valid_r;
  out_item_t          out_item_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic signed [31:0] cur_coord;
  logic signed [31:0] cur_centre;
  logic signed [32:0] diff;
  logic [31:0]        absd_nxt;
  logic signed [65:0] centre_sum;
  logic signed [31:0] centre_sat;
  logic [64:0]        acc_sum;
  logic [63:0]        acc_sat;
  logic [64:0]        thr_sum;
  logic [63:0]        thr_nxt;
  logic               far_bit;

  logic               is_query;
  logic [2:0]         count_nxt;
  logic               far_nxt;
  logic               closer_nxt;
  decision_t          decision;
  logic               out_free;
  logic               pop;
  logic               advance;
  logic               emit;
  logic               use_mul;

  // ---------------- datapath helpers ----------------
  assign cur_coord  = axis_coord(item_r, axis_r);
  assign cur_centre = centre_r[axis_r];
  assign diff       = {cur_coord[31], cur_coord} - {cur_centre[31], cur_centre};
  assign absd_nxt   = diff[32] ? 32'(-diff) : diff[31:0];

  assign centre_sum = prod_r + $signed({46'd0, cfg.voxel_size[VOXEL_SIZE_W-1:1]});
  assign centre_sat = (centre_sum > I32_MAX) ? 32'sh7FFF_FFFF :
                      (centre_sum < I32_MIN) ? 32'sh8000_0000 : centre_sum[31:0];

  assign acc_sum = {1'b0, acc_r} + {1'b0, prod_r[63:0]};
  assign acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];
  assign thr_sum = {1'b0, acc_r} + {1'b0, EPS_Q32};
  assign thr_nxt = thr_sum[64] ? '1 : thr_sum[63:0];

  // twice the offset beyond the voxel size
  assign far_bit = {absd_r, 1'b0} > {12'd0, cfg.voxel_size};

  assign mul_p = mul_a * mul_b;

  // ---------------- finish-time updates ----------------
  assign is_query = (item_r.kind == KIND_QUERY);

  always_comb begin
    if (is_query) begin
      count_nxt  = '0;
      far_nxt    = 1'b0;
      closer_nxt = 1'b0;
    end else begin
      count_nxt  = (count_r < COUNT_MAX) ? count_r + 3'd1 : count_r;
      far_nxt    = (count_r == '0) ? far_run_r : far_r;
      closer_nxt = closer_r || ((count_r < MATCH_POINTS) && (acc_r < thr_r));
    end
  end

  always_comb begin
    decision = DEC_ADD_DS;
    if (cfg.estimator_ready && (count_nxt != '0)) begin
      if (far_nxt) begin
        decision = DEC_ADD_RAW;
      end else if ((count_nxt >= MATCH_POINTS) && closer_nxt) begin
        decision = DEC_DROP;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_entry.kind == KIND_QUERY) begin
            state_nxt = BK_RECIP;
          end else if (count_r < MATCH_POINTS) begin
            state_nxt = BK_DIFF;
          end else begin
            state_nxt = BK_FINISH;
          end
        end
      end
      BK_RECIP:  state_nxt = BK_SCALE;
      BK_SCALE:  state_nxt = BK_CENTRE;
      BK_CENTRE: state_nxt = (axis_r == AXIS_LAST) ? BK_DIFF : BK_RECIP;
      BK_DIFF:   state_nxt = BK_SQUARE;
      BK_SQUARE: state_nxt = BK_ACCUM;
      BK_ACCUM:  state_nxt = (axis_r == AXIS_LAST) ? BK_FINISH : BK_DIFF;
      BK_FINISH: begin
        if (!item_r.last || out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    pop     = 1'b0;
    advance = 1'b0;
    emit    = 1'b0;
    use_mul = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      BK_IDLE: begin
        pop = q_valid;
      end
      BK_RECIP: begin
        use_mul = 1'b1;
        mul_a   = {cur_coord[31], cur_coord};
        mul_b   = {1'b0, cfg.voxel_reciprocal};
      end
      BK_SCALE: begin
        // floor(coord * reciprocal / 2^32) times the voxel size
        use_mul = 1'b1;
        mul_a   = prod_r[64:32];
        mul_b   = {12'd0, cfg.voxel_size};
      end
      BK_SQUARE: begin
        use_mul = 1'b1;
        mul_a   = {1'b0, absd_r};
        mul_b   = {1'b0, absd_r};
      end
      BK_FINISH: begin
        advance = !item_r.last || out_free;
        emit    = item_r.last && out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign q_ready = pop;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      axis_r      <= '0;
      count_r     <= '0;
      far_r       <= 1'b0;
      closer_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        axis_r <= '0;
      end else if ((state_r == BK_CENTRE) || (state_r == BK_ACCUM)) begin
        axis_r <= (axis_r == AXIS_LAST) ? 2'd0 : axis_r + 2'd1;
      end
      if (advance) begin
        count_r  <= count_nxt;
        far_r    <= far_nxt;
        closer_r <= closer_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r    <= q_entry;
      far_run_r <= 1'b1;
      acc_r     <= '0;
    end
    if (use_mul) begin
      prod_r <= mul_p;
    end
    if (state_r == BK_CENTRE) begin
      centre_r[axis_r] <= centre_sat;
    end
    if (state_r == BK_DIFF) begin
      absd_r <= absd_nxt;
    end
    if (state_r == BK_SQUARE) begin
      far_run_r <= far_run_r && far_bit;
    end
    if (state_r == BK_ACCUM) begin
      acc_r <= acc_sat;
    end
    if (advance && is_query) begin
      qpoint_r[0] <= item_r.x;
      qpoint_r[1] <= item_r.y;
      qpoint_r[2] <= item_r.z;
      thr_r       <= thr_nxt;
    end
    if (emit) begin
      out_item_r.decision <= decision;
      out_item_r.point_x  <= is_query ? item_r.x : qpoint_r[0];
      out_item_r.point_y  <= is_query ? item_r.y : qpoint_r[1];
      out_item_r.point_z  <= is_query ? item_r.z : qpoint_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ src/voxel_map_point_add_filter.sv @@
// Voxel map point add filter, top level: configuration registers, front end
// and back end. Depends on vmpf_pkg, vmpf_front and vmpf_back.
//
// Decides whether a world-frame point joins a voxel map. A query transaction
// (operation 0) carries the point; neighbor transactions (operation 1) that
// follow carry the nearest map points, nearest first. The transaction marked
// last_of_query produces one result: decision (0 add with downsampling, 1 add
// without downsampling, 2 drop) and the query point. Neighbors with no open
// query are dropped in the front end; a new query abandons an open one. The
// front end takes transactions into a short queue (QUEUE_DEPTH entries) as
// long as it has room, so the input side keeps moving while the back end
// works. The back end runs one transaction at a time through a sequencer
// around a single 33x33 signed multiplier: a query takes one step to
// take it from the queue, per axis three steps for the voxel center - two
// multiplies, then offset and saturate - then per axis a difference, square
// and saturating accumulate for the squared distance, and one to finish; a
// neighbor among the first five skips the center steps; a later one only
// is taken and finished. A result sits in an output register, so the back end
// keeps working on the next transaction until it has a new result to place
// there; while that register is still full it waits in its finish step.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 voxel
// size, 1 voxel reciprocal, 2 estimator ready); other indexes are ignored.
// Write only while the block is idle.
module voxel_map_point_add_filter import vmpf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t   cfg_r;
  logic   q_valid;
  logic   q_ready;
  entry_t q_entry;

  // Reset values: 0.5 m voxel, reciprocal 2.0, estimator not ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voxel_size       <= VOXEL_SIZE_W'(32768);
      cfg_r.voxel_reciprocal <= RECIP_W'(131072);
      cfg_r.estimator_ready  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOXEL_SIZE:  cfg_r.voxel_size       <= cfg_wdata[VOXEL_SIZE_W-1:0];
        CFG_VOXEL_RECIP: cfg_r.voxel_reciprocal <= cfg_wdata[RECIP_W-1:0];
        CFG_EST_READY:   cfg_r.estimator_ready  <= cfg_wdata[0];
        default:         cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Classification and queueing
  vmpf_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  // Arithmetic sequencer, per-query state and result register
  vmpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
